// ===== hw/rtl/qoi_pkg.sv =====
// Shared types and constants for the QOI chunk decoder.
// Used by the front end, the command queue, the back end and the top level.
package qoi_pkg;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} px_t;

	localparam logic [2:0] OP_RGB   = 3'd0;
	localparam logic [2:0] OP_RGBA  = 3'd1;
	localparam logic [2:0] OP_INDEX = 3'd2;
	localparam logic [2:0] OP_DIFF  = 3'd3;
	localparam logic [2:0] OP_LUMA  = 3'd4;
	localparam logic [2:0] OP_RUN   = 3'd5;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_RGB  = 2'd1;
	localparam logic [1:0] KIND_RGBA = 2'd2;
	localparam logic [1:0] KIND_LUMA = 2'd3;

	localparam logic [7:0] CODE_RGB  = 8'hfe;
	localparam logic [7:0] CODE_RGBA = 8'hff;
	localparam logic [1:0] PFX_INDEX = 2'b00;
	localparam logic [1:0] PFX_DIFF  = 2'b01;
	localparam logic [1:0] PFX_LUMA  = 2'b10;

	localparam logic [2:0] CHAN_ALPHA = 3'd4;
	localparam px_t PX_START = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

	// p0..p2 carry assembled bytes (LUMA: p0 holds the green delta);
	// p3 carries the last code byte of the operation
	typedef struct packed {
		logic [2:0] op;
		logic       clr;
		logic [7:0] p0;
		logic [7:0] p1;
		logic [7:0] p2;
		logic [7:0] p3;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [5:0] color_hash(input px_t p);
		logic [5:0] s;
		s = p.r[5:0] * 6'd3 + p.g[5:0] * 6'd5 + p.b[5:0] * 6'd7 + p.a[5:0] * 6'd11;
		return s;
	endfunction

endpackage

// ===== hw/rtl/qoi_front.sv =====
// Front end: takes chunk bytes, gathers multi-byte operations, pushes commands.
// Depends on qoi_pkg for the command format and opcodes.
module qoi_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	input  logic             in_start,
	input  qoi_pkg::q_stat_t q_stat,
	output logic             in_ready,
	output logic             push,
	output qoi_pkg::cmd_t    push_cmd
);

	logic [2:0] cnt_q;
	logic [1:0] kind_q;
	logic [5:0] luma_q;
	logic [7:0] b0_q, b1_q, b2_q;
	logic       clr_q;

	logic       acc;
	logic [2:0] cnt_eff;
	logic       clr_eff;
	logic [2:0] pos3;
	logic [1:0] pos;

	assign in_ready = !q_stat.full;
	assign acc      = in_valid && in_ready;
	assign cnt_eff  = in_start ? 3'd0 : cnt_q;
	assign clr_eff  = in_start || clr_q;
	assign pos3     = (kind_q == qoi_pkg::KIND_RGBA) ? (3'd4 - cnt_eff) : (3'd3 - cnt_eff);
	assign pos      = pos3[1:0];

	always_comb begin
		push         = 1'b0;
		push_cmd.op  = qoi_pkg::OP_RUN;
		push_cmd.clr = clr_eff;
		push_cmd.p0  = b0_q;
		push_cmd.p1  = b1_q;
		push_cmd.p2  = b2_q;
		push_cmd.p3  = in_byte;
		if (cnt_eff != 3'd0) begin
			if (kind_q == qoi_pkg::KIND_LUMA) begin
				push        = acc;
				push_cmd.op = qoi_pkg::OP_LUMA;
				push_cmd.p0 = {2'b00, luma_q};
			end else if (cnt_eff == 3'd1) begin
				push = acc;
				if (kind_q == qoi_pkg::KIND_RGBA) begin
					push_cmd.op = qoi_pkg::OP_RGBA;
				end else begin
					push_cmd.op = qoi_pkg::OP_RGB;
					push_cmd.p2 = in_byte;
				end
			end
		end else if (in_byte != qoi_pkg::CODE_RGB && in_byte != qoi_pkg::CODE_RGBA) begin
			case (in_byte[7:6])
				qoi_pkg::PFX_INDEX: begin
					push        = acc;
					push_cmd.op = qoi_pkg::OP_INDEX;
				end
				qoi_pkg::PFX_DIFF: begin
					push        = acc;
					push_cmd.op = qoi_pkg::OP_DIFF;
				end
				qoi_pkg::PFX_LUMA: begin
					push = 1'b0;
				end
				default: begin
					push        = acc;
					push_cmd.op = qoi_pkg::OP_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 3'd0;
			kind_q <= qoi_pkg::KIND_NONE;
			luma_q <= 6'd0;
			clr_q  <= 1'b0;
		end else if (acc) begin
			// a start flag drops any pending operation; keep the clear until a command carries it
			clr_q <= push ? 1'b0 : clr_eff;
			if (cnt_eff != 3'd0) begin
				cnt_q <= cnt_eff - 3'd1;
				if (cnt_eff == 3'd1) begin
					kind_q <= qoi_pkg::KIND_NONE;
				end
			end else if (in_byte == qoi_pkg::CODE_RGB) begin
				cnt_q  <= 3'd3;
				kind_q <= qoi_pkg::KIND_RGB;
			end else if (in_byte == qoi_pkg::CODE_RGBA) begin
				cnt_q  <= 3'd4;
				kind_q <= qoi_pkg::KIND_RGBA;
			end else if (in_byte[7:6] == qoi_pkg::PFX_LUMA) begin
				cnt_q  <= 3'd1;
				kind_q <= qoi_pkg::KIND_LUMA;
				luma_q <= in_byte[5:0];
			end else begin
				cnt_q  <= 3'd0;
				kind_q <= qoi_pkg::KIND_NONE;
			end
		end
	end

	// payload bytes of RGB and RGBA
	always_ff @(posedge clk) begin
		if (acc && cnt_eff != 3'd0 && kind_q != qoi_pkg::KIND_LUMA) begin
			case (pos)
				2'd0:    b0_q <= in_byte;
				2'd1:    b1_q <= in_byte;
				2'd2:    b2_q <= in_byte;
				default: b2_q <= b2_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/qoi_cmdq.sv =====
// Short command queue between the front and back ends.
// Depends on qoi_pkg for the command and status types.
module qoi_cmdq #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qoi_pkg::cmd_t    push_cmd,
	input  logic             pop,
	output qoi_pkg::cmd_t    head,
	output qoi_pkg::q_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	qoi_pkg::cmd_t   ent_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign stat.full  = (cnt_q == FULL);
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/qoi_back.sv =====
// Back end: executes commands against the previous pixel and the color table,
// emits pixels through an output register. Depends on qoi_pkg.
module qoi_back (
	input  logic             clk,
	input  logic             arst_n,
	input  qoi_pkg::cmd_t    head,
	input  qoi_pkg::q_stat_t q_stat,
	input  logic [2:0]       channels,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output qoi_pkg::px_t     out_px,
	output logic             out_alpha_valid,
	output logic             out_last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]    state_q;
	qoi_pkg::px_t  pix_q;
	logic [5:0]    run_q;
	logic [63:0]   tvalid_q;
	logic [31:0]   tbl_mem [64];
	logic [31:0]   rd_data_q;
	logic          rd_ok_q;

	qoi_pkg::px_t  prev;
	qoi_pkg::px_t  nxt;
	logic [7:0]    dg, dr, db;
	logic          load;
	logic [5:0]    wr_hash;

	assign pop     = (state_q == ST_IDLE) && !q_stat.empty;
	assign prev    = head.clr ? qoi_pkg::PX_START : pix_q;
	assign load    = (state_q == ST_EMIT) && (!out_valid || out_ready);
	assign wr_hash = qoi_pkg::color_hash(pix_q);

	assign dg = {2'b00, head.p0[5:0]} + 8'd224;
	assign dr = dg + {4'b0000, head.p3[7:4]} + 8'd248;
	assign db = dg + {4'b0000, head.p3[3:0]} + 8'd248;

	always_comb begin
		nxt = prev;
		case (head.op)
			qoi_pkg::OP_RGB: begin
				nxt.r = head.p0;
				nxt.g = head.p1;
				nxt.b = head.p2;
			end
			qoi_pkg::OP_RGBA: begin
				nxt = '{r: head.p0, g: head.p1, b: head.p2, a: head.p3};
			end
			qoi_pkg::OP_DIFF: begin
				nxt.r = prev.r + {6'd0, head.p3[5:4]} + 8'd254;
				nxt.g = prev.g + {6'd0, head.p3[3:2]} + 8'd254;
				nxt.b = prev.b + {6'd0, head.p3[1:0]} + 8'd254;
			end
			qoi_pkg::OP_LUMA: begin
				nxt.r = prev.r + dr;
				nxt.g = prev.g + dg;
				nxt.b = prev.b + db;
			end
			default: begin
				nxt = prev;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_data_q <= tbl_mem[head.p3[5:0]];
		end
		if (load) begin
			tbl_mem[wr_hash] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pix_q    <= qoi_pkg::PX_START;
			run_q    <= 6'd0;
			tvalid_q <= '0;
			rd_ok_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						// an entry cleared by the start flag reads as zero
						rd_ok_q <= tvalid_q[head.p3[5:0]] && !head.clr;
						if (head.clr) begin
							tvalid_q <= '0;
						end
						pix_q <= nxt;
						run_q <= (head.op == qoi_pkg::OP_RUN) ? head.p3[5:0] : 6'd0;
						state_q <= (head.op == qoi_pkg::OP_INDEX) ? ST_READ : ST_EMIT;
					end
				end
				ST_READ: begin
					pix_q   <= rd_ok_q ? rd_data_q : '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						tvalid_q[wr_hash] <= 1'b1;
						if (run_q == 6'd0) begin
							state_q <= ST_IDLE;
						end else begin
							run_q <= run_q - 6'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_px          <= pix_q;
			out_last        <= (run_q == 6'd0);
			out_alpha_valid <= (channels == qoi_pkg::CHAN_ALPHA);
		end
	end

endmodule

// ===== hw/rtl/qoi_chunk_decoder.sv =====
// QOI chunk decoder: one chunk byte per input word, one pixel per output word.
// Path: the last byte of an op is pushed into the command queue; the back end pops it into
// pix_q (INDEX via the READ state for the table read) and then into the output register.
// The back end runs one command at a time; bytes keep arriving meanwhile, up to queue depth.
// Reset: arst_n clears control state, the previous pixel to opaque black and all table
// valid bits at once; channels resets to 4.
module qoi_chunk_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // code_byte
	input  logic        s_axis_tuser,  // start_image
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // red, green, blue, alpha
	output logic        m_axis_tuser,  // alpha_valid
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);

	logic             push;
	qoi_pkg::cmd_t    push_cmd;
	qoi_pkg::cmd_t    head;
	qoi_pkg::q_stat_t q_stat;
	logic             pop;
	logic [2:0]       channels_q;
	qoi_pkg::px_t     out_px;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {out_px.a, out_px.b, out_px.g, out_px.r};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_q <= qoi_pkg::CHAN_ALPHA;
		end else if (cfg_valid && cfg_ready) begin
			channels_q <= cfg_data;
		end
	end

	qoi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.in_start (s_axis_tuser),
		.q_stat   (q_stat),
		.in_ready (s_axis_tready),
		.push     (push),
		.push_cmd (push_cmd)
	);

	qoi_cmdq #(
		.DEPTH (QUEUE_DEPTH)
	) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	qoi_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.q_stat          (q_stat),
		.channels        (channels_q),
		.pop             (pop),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_px          (out_px),
		.out_alpha_valid (m_axis_tuser),
		.out_last        (m_axis_tlast)
	);

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("command pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("command popped from an empty queue");

	a_alpha_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !$past(m_axis_tvalid) && $stable(channels_q))
		|-> (m_axis_tuser == (channels_q == qoi_pkg::CHAN_ALPHA)))
		else $error("alpha flag does not match channel setting");
`endif

endmodule

// ===== test/qoi_chunk_decoder_tb.sv =====
// Self-checking bench for qoi_chunk_decoder: streams chunk bytes with random gaps and
// back-pressure, predicts every pixel in-bench and checks each output word in order.
// Depends on qoi_pkg (pixel type, op tags, pending kinds, channel code) and the block.
`timescale 1ns / 1ps

module qoi_chunk_decoder_tb;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int PHASE_BYTES = 58;
	localparam logic [1:0] RUN_PREFIX = 2'b11;

	typedef struct packed {
		logic [7:0] code;
		logic       start;
	} chunk_byte_t;

	typedef struct packed {
		qoi_pkg::px_t pix;
		logic         alpha_ok;
		logic         last_px;
	} pixel_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;  // code_byte
	logic        s_axis_tuser = 1'b0;  // start_image
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // red, green, blue, alpha
	logic        m_axis_tuser;         // alpha_valid
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_data = 3'd0;

	// decoder image as the bench tracks it
	qoi_pkg::px_t prev_px;
	qoi_pkg::px_t seen_color [64];
	logic [2:0]   payload_left;
	logic [1:0]   op_kind;
	logic [5:0]   luma_dg;
	logic [2:0]   chan_reg;

	chunk_byte_t chunk_q [$];
	pixel_exp_t  pixel_due [$];
	chunk_byte_t drive_item;

	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	bit   in_idle_on = 1'b1;
	bit   out_idle_on = 1'b1;
	bit   restart_next = 1'b0;
	int   in_gap = 0;
	int   out_hold = 0;
	int   fails = 0;
	int   queued = 0;
	int   bytes_in = 0;
	int   pixels_checked = 0;
	int   cycles = 0;
	int   settings_run = 1;

	logic [2:0] chan_plan [8] = '{3'd3, 3'd0, 3'd7, 3'd4, 3'd2, 3'd5, 3'd6, 3'd1};

	qoi_chunk_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap(input bit on);
		return on ? int'($urandom_range(0, 14)) : 0;
	endfunction

	task automatic clear_image();
		prev_px = qoi_pkg::PX_START;
		foreach (seen_color[i]) seen_color[i] = '0;
		payload_left = 3'd0;
		op_kind = qoi_pkg::KIND_NONE;
		luma_dg = 6'd0;
	endtask

	task automatic remember_color();
		logic [5:0] slot;
		slot = 6'(prev_px.r * 3 + prev_px.g * 5 + prev_px.b * 7 + prev_px.a * 11);
		seen_color[slot] = prev_px;
	endtask

	task automatic emit_pixel(input logic last_px);
		pixel_due.push_back('{pix: prev_px, alpha_ok: (chan_reg == qoi_pkg::CHAN_ALPHA),
			last_px: last_px});
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic start);
		logic [7:0] dg;
		logic [7:0] dr;
		logic [7:0] db;
		int pos;
		int n;
		if (start)
			clear_image();
		if (payload_left != 0) begin
			if (op_kind == qoi_pkg::KIND_LUMA) begin
				dg = {2'b00, luma_dg} + 8'd224;
				dr = dg + {4'b0000, b[7:4]} + 8'd248;
				db = dg + {4'b0000, b[3:0]} + 8'd248;
				prev_px.r = prev_px.r + dr;
				prev_px.g = prev_px.g + dg;
				prev_px.b = prev_px.b + db;
				payload_left = 3'd0;
			end else begin
				pos = (op_kind == qoi_pkg::KIND_RGBA) ? 4 - payload_left : 3 - payload_left;
				case (pos)
					0: prev_px.r = b;
					1: prev_px.g = b;
					2: prev_px.b = b;
					default: prev_px.a = b;
				endcase
				payload_left = payload_left - 3'd1;
				if (payload_left != 0)
					return;
			end
			op_kind = qoi_pkg::KIND_NONE;
			remember_color();
			emit_pixel(1'b1);
			return;
		end
		if (b == qoi_pkg::CODE_RGB) begin
			op_kind = qoi_pkg::KIND_RGB;
			payload_left = 3'd3;
			return;
		end
		if (b == qoi_pkg::CODE_RGBA) begin
			op_kind = qoi_pkg::KIND_RGBA;
			payload_left = 3'd4;
			return;
		end
		case (b[7:6])
			qoi_pkg::PFX_INDEX: prev_px = seen_color[b[5:0]];
			qoi_pkg::PFX_DIFF: begin
				prev_px.r = prev_px.r + {6'd0, b[5:4]} + 8'd254;
				prev_px.g = prev_px.g + {6'd0, b[3:2]} + 8'd254;
				prev_px.b = prev_px.b + {6'd0, b[1:0]} + 8'd254;
			end
			qoi_pkg::PFX_LUMA: begin
				luma_dg = b[5:0];
				op_kind = qoi_pkg::KIND_LUMA;
				payload_left = 3'd1;
				return;
			end
			default: begin
				n = b[5:0] + 1;
				remember_color();
				for (int i = 0; i < n; i++)
					emit_pixel(i == n - 1);
				return;
			end
		endcase
		remember_color();
		emit_pixel(1'b1);
	endtask

	task automatic check_field(input string fname, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			fails++;
		end
	endtask

	task automatic check_pixel();
		pixel_exp_t e;
		if (pixel_due.size() == 0) begin
			$error("pixel word with none pending: tdata %h", m_axis_tdata);
			fails++;
			return;
		end
		e = pixel_due.pop_front();
		pixels_checked++;
		check_field("red", e.pix.r, m_axis_tdata[7:0]);
		check_field("green", e.pix.g, m_axis_tdata[15:8]);
		check_field("blue", e.pix.b, m_axis_tdata[23:16]);
		check_field("alpha", e.pix.a, m_axis_tdata[31:24]);
		check_field("alpha_valid", {7'd0, e.alpha_ok}, {7'd0, m_axis_tuser});
		check_field("last_of_run", {7'd0, e.last_px}, {7'd0, m_axis_tlast});
	endtask

	// sample both streams; predict on every accepted code byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
			out_fire <= 1'b0;
		end else begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			out_fire <= m_axis_tvalid && m_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				bytes_in++;
				decode_byte(s_axis_tdata, s_axis_tuser);
			end
			if (m_axis_tvalid && m_axis_tready)
				check_pixel();
		end
	end

	// input driver: hold a word until taken, then idle for its drawn gap
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !in_fire) begin
			// hold the word
		end else if (in_gap != 0) begin
			s_axis_tvalid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (chunk_q.size() != 0) begin
			drive_item = chunk_q.pop_front();
			s_axis_tdata <= drive_item.code;
			s_axis_tuser <= drive_item.start;
			s_axis_tvalid <= 1'b1;
			in_gap <= pick_gap(in_idle_on);
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// output back-pressure: after each taken word drop ready for a drawn stretch
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (m_axis_tready) begin
			if (out_fire) begin
				out_hold = pick_gap(out_idle_on);
				if (out_hold != 0)
					m_axis_tready <= 1'b0;
			end
		end else if (out_hold > 1) begin
			out_hold = out_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels pending", cycles, pixel_due.size());
			$display("qoi_chunk_decoder_tb NOT OK");
			$finish;
		end
	end

	task automatic put_byte(input logic [7:0] code, input logic start);
		chunk_q.push_back('{code: code, start: start});
		queued++;
	endtask

	task automatic set_channels(input logic [2:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		chan_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain everything, then cover the pipeline tail after payload-only bytes
	task automatic settle();
		while (chunk_q.size() != 0 || s_axis_tvalid || pixel_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic add_chunk();
		int pick;
		int cut;
		int k;
		logic st;
		logic [5:0] low6;
		logic [7:0] rb;
		st = restart_next || ($urandom_range(0, 49) == 0);
		restart_next = 1'b0;
		pick = $urandom_range(0, 99);
		low6 = 6'($urandom_range(0, 63));
		rb = 8'($urandom_range(0, 255));
		if (pick < 8) begin
			put_byte(qoi_pkg::CODE_RGB, st);
			repeat (3) put_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (pick < 16) begin
			put_byte(qoi_pkg::CODE_RGBA, st);
			repeat (4) put_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (pick < 38) begin
			put_byte({qoi_pkg::PFX_INDEX, low6}, st);
		end else if (pick < 58) begin
			put_byte({qoi_pkg::PFX_DIFF, low6}, st);
		end else if (pick < 78) begin
			put_byte({qoi_pkg::PFX_LUMA, low6}, st);
			put_byte(rb, 1'b0);
		end else if (pick < 90) begin
			low6 = 6'($urandom_range(0, 5));
			put_byte({RUN_PREFIX, low6}, st);
		end else if (pick < 93) begin
			low6 = 6'($urandom_range(0, 61));
			put_byte({RUN_PREFIX, low6}, st);
		end else if (pick < 97) begin
			put_byte(rb, st);
		end else begin
			// truncated op; the next chunk restarts the image
			k = $urandom_range(0, 2);
			case (k)
				0: begin put_byte(qoi_pkg::CODE_RGB, st); cut = $urandom_range(0, 2); end
				1: begin put_byte(qoi_pkg::CODE_RGBA, st); cut = $urandom_range(0, 3); end
				default: begin put_byte({qoi_pkg::PFX_LUMA, low6}, st); cut = 0; end
			endcase
			repeat (cut) put_byte(8'($urandom_range(0, 255)), 1'b0);
			restart_next = 1'b1;
		end
	endtask

	initial begin
		int target;
		clear_image();
		chan_reg = qoi_pkg::CHAN_ALPHA;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: every op and its extremes under the reset channel setting
		put_byte(qoi_pkg::CODE_RGBA, 1'b1);
		put_byte(8'h12, 1'b0);
		put_byte(8'h34, 1'b0);
		put_byte(8'h56, 1'b0);
		put_byte(8'h78, 1'b0);
		put_byte(8'h40, 1'b0);
		put_byte(8'h7f, 1'b0);
		put_byte(8'h6a, 1'b0);
		put_byte(8'h80, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'hbf, 1'b0);
		put_byte(8'hff, 1'b0);
		// payload bytes that look like op tags
		put_byte(qoi_pkg::CODE_RGB, 1'b0);
		put_byte(8'hff, 1'b0);
		put_byte(8'hfe, 1'b0);
		put_byte(8'hff, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h3f, 1'b0);
		put_byte(8'hc0, 1'b0);
		put_byte(8'hfd, 1'b0);
		// start flag abandons a pending RGB op
		put_byte(qoi_pkg::CODE_RGB, 1'b0);
		put_byte(8'h11, 1'b0);
		put_byte(8'h55, 1'b1);
		settle();

		foreach (chan_plan[p]) begin
			set_channels(chan_plan[p]);
			settings_run++;
			in_idle_on = !(p == 3 || p == 5);
			out_idle_on = !(p == 3 || p == 6);
			target = queued + PHASE_BYTES;
			while (queued < target)
				add_chunk();
			settle();
		end

		$display("%0d code bytes in, %0d pixels checked, %0d channel settings",
			bytes_in, pixels_checked, settings_run);
		$display("ops covered: RGB, RGBA, INDEX, DIFF, LUMA, RUN, restarts and truncated ops");
		if (fails == 0) begin
			$display("qoi_chunk_decoder_tb OK");
		end else begin
			$display("qoi_chunk_decoder_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/qoi_pkg.sv
hw/rtl/qoi_front.sv
hw/rtl/qoi_cmdq.sv
hw/rtl/qoi_back.sv
hw/rtl/qoi_chunk_decoder.sv
test/qoi_chunk_decoder_tb.sv
